FILE: hdl/dd_pkg.sv
// Shared constants, types and the disk mask helper function of the disk dilation block.
package dd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 20;

    // Field and register widths
    localparam int PIX_W    = 16;
    localparam int RAD_W    = 5;
    localparam int IMGW_W   = 12;
    localparam int IMGH_W   = 13;
    localparam int OCOL_W   = 11;
    localparam int OROW_W   = 12;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 2;

    // Vertical window per column: rows r+R down to r-R
    localparam int WIN_W   = 2 * MAX_RADIUS + 1;
    localparam int WIN_IW  = $clog2(WIN_W);
    localparam int VEC_W   = MAX_RADIUS + 1;
    localparam int NCELL   = WIN_W;
    localparam int CELL_IW = $clog2(NCELL);
    localparam int SQ_W    = 2 * CELL_IW;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
    localparam int MAX_D  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int D_W    = $clog2(MAX_D + 1);
    localparam int VAL_AW = D_W;
    localparam int VAL_DEPTH = 2 ** VAL_AW;
    localparam int P_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_D + 1);

    localparam logic [REGIDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_HEIGHT = 2'd2;

    // One column entry moving down the cell chain
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [VEC_W-1:0] vec;
    } cell_data_t;

    // Bit k set when a blank at vertical distance k, in the column seen by
    // cell j, lies inside the disk of radius r.
    function automatic logic [VEC_W-1:0] disk_mask(input logic [RAD_W-1:0] r,
                                                   input logic [CELL_IW-1:0] j);
        logic [VEC_W-1:0]   m;
        logic [CELL_IW-1:0] rr;
        logic [CELL_IW-1:0] dx;
        logic [SQ_W-1:0]    dx_sq;
        logic [SQ_W-1:0]    r_sq;
        m     = '0;
        rr    = CELL_IW'(r);
        dx    = (j >= rr) ? (j - rr) : (rr - j);
        dx_sq = SQ_W'(dx) * SQ_W'(dx);
        r_sq  = SQ_W'(rr) * SQ_W'(rr);
        if (j <= {rr[CELL_IW-2:0], 1'b0}) begin
            for (int k = 0; k < VEC_W; k++) begin
                m[k] = (k <= int'(r)) && ((SQ_W'(k * k) + dx_sq) <= r_sq);
            end
        end
        return m;
    endfunction

endpackage

FILE: hdl/dd_if.sv
// Stream interfaces for pixel beats in and result beats out.
interface dd_pix_if;
    import dd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [PIX_W-1:0] pixel_value;

    modport source (output valid, cmd, pixel_value, input ready);
    modport sink   (input valid, cmd, pixel_value, output ready);
endinterface

interface dd_res_if;
    import dd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] mask_value;
    logic [OCOL_W-1:0]       out_col;
    logic [OROW_W-1:0]       out_row;
    logic                    last_of_frame;

    modport source (output valid, mask_value, out_col, out_row, last_of_frame, input ready);
    modport sink   (input valid, mask_value, out_col, out_row, last_of_frame, output ready);
endinterface

FILE: hdl/dd_colstage.sv
// Per-column blank history memory and vertical distance vector.
module dd_colstage (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [dd_pkg::COL_W-1:0]   rd_col,
    input  logic                       upd_en,
    input  logic [dd_pkg::COL_W-1:0]   upd_col,
    input  logic [dd_pkg::ROW_W-1:0]   upd_row,
    input  logic                       upd_blank,
    input  logic [dd_pkg::RAD_W-1:0]   radius,
    output dd_pkg::cell_data_t         col_out
);
    import dd_pkg::*;

    logic [WIN_W-1:0] word_mem [MAX_WIDTH];
    logic [WIN_W-1:0] rd_word_reg;
    logic [WIN_W-1:0] row_mask;
    logic [WIN_W-1:0] new_word;
    logic [VEC_W-1:0] vec;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= word_mem[rd_col];
        end
        if (upd_en)
        begin
            word_mem[upd_col] <= new_word;
        end
    end

    // bit i holds row upd_row - i; drop rows before the frame start
    always_comb
    begin
        for (int i = 0; i < WIN_W; i++)
        begin
            row_mask[i] = (ROW_W'(i) <= upd_row);
        end
        new_word = {rd_word_reg[WIN_W-2:0], upd_blank} & row_mask;
        for (int k = 0; k < VEC_W; k++)
        begin
            if (k <= int'(radius))
            begin
                vec[k] = new_word[WIN_IW'(radius) + WIN_IW'(k)]
                       | new_word[WIN_IW'(radius) - WIN_IW'(k)];
            end
            else
            begin
                vec[k] = 1'b0;
            end
        end
    end

    assign col_out.row = upd_row;
    assign col_out.vec = vec;

endmodule

FILE: hdl/dd_cell.sv
// One cell of the horizontal chain: holds a column entry, tests it against the disk.
module dd_cell (
    input  logic                       clk,
    input  logic                       shift_en,
    input  dd_pkg::cell_data_t         d_in,
    output dd_pkg::cell_data_t         d_out,
    input  logic [dd_pkg::VEC_W-1:0]   mask,
    input  logic [dd_pkg::ROW_W-1:0]   want_row,
    output logic                       hit
);
    import dd_pkg::*;

    cell_data_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d_in;
        end
    end

    assign d_out = data_reg;
    assign hit   = (data_reg.row == want_row) && (|(data_reg.vec & mask));

endmodule

FILE: hdl/disk_dilation_of_blank_pixels.sv
// Top level: streaming disk dilation of blank pixels with APB configuration.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  pix     | in  | valid / ready | cmd, pixel_value
//  res     | out | valid / ready | mask_value, out_col, out_row, last_of_frame
//  apb     | in  | psel/penable  | paddr, pwdata, prdata (pready tied high)
//
// Each item is accepted in ST_IDLE, then moves to ST_SHIFT (column memory
// read-modify-write and chain shift), and on to ST_EMIT when it produces a
// result (evaluating the cell chain into the result register). The column memory
// read port and the single-ported value ring mean no new item is taken meanwhile.
// Reset clears the counters and the FSM; memories need no clearing since rows
// from before the frame start are masked by row index.
// A stalled result holds in the output register; the next item is still taken
// while it waits, and only an item that needs that register stalls.
module disk_dilation_of_blank_pixels (
    input  logic                         clk,
    input  logic                         rst_n,
    dd_pix_if.sink                       pix,
    dd_res_if.source                     res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dd_pkg::PADDR_W-1:0]   paddr,
    input  logic [dd_pkg::PDATA_W-1:0]   pwdata,
    output logic [dd_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready
);
    import dd_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_EMIT} state_t;

    state_t state_reg, state_next;

    // configuration
    logic [RAD_W-1:0]  radius_reg, radius_next;
    logic [IMGW_W-1:0] width_reg, width_next;
    logic [IMGH_W-1:0] height_reg, height_next;

    // stream position counters
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [P_W-1:0]   p_reg, p_next;
    logic [COL_W-1:0] out_c_reg, out_c_next;
    logic [ROW_W-1:0] out_r_reg, out_r_next;

    // result register
    logic                    res_valid_reg, res_valid_next;
    logic signed [PIX_W-1:0] res_val_reg, res_val_next;
    logic [OCOL_W-1:0]       res_col_reg, res_col_next;
    logic [OROW_W-1:0]       res_row_reg, res_row_next;
    logic                    res_last_reg, res_last_next;

    // item held between accept and chain update
    logic [COL_W-1:0]        it_col_reg;
    logic [ROW_W-1:0]        it_row_reg;
    logic                    it_blank_reg;
    logic signed [PIX_W-1:0] it_val_reg;
    logic                    it_wr_reg;
    logic [VAL_AW-1:0]       it_waddr_reg;
    logic                    emit_reg;
    logic [COL_W-1:0]        kcol_reg;
    logic [ROW_W-1:0]        krow_reg;
    logic                    klast_reg;

    // delayed values ring
    logic signed [PIX_W-1:0] value_mem [VAL_DEPTH];
    logic signed [PIX_W-1:0] val_rdata_reg;
    logic [VAL_AW-1:0]       val_raddr;

    // effective (clamped) settings
    logic [RAD_W-1:0]  r_eff;
    logic [IMGW_W-1:0] w_eff;
    logic [IMGH_W-1:0] h_eff;
    logic [D_W-1:0]    r_ext;
    logic [D_W-1:0]    w_ext;
    logic [D_W-1:0]    d_eff;

    logic take;
    logic row_act;
    logic ignore;
    logic cfg_wr;
    logic col_wrap;
    logic out_wrap;
    logic emit_now;
    logic k_over;
    logic k_last;
    logic near;
    logic signed [PIX_W-1:0] keep_val;

    cell_data_t             col_entry;
    cell_data_t             link [NCELL];
    logic [VEC_W-1:0]       cell_mask [NCELL];
    logic [NCELL-1:0]       hits;
    logic [ROW_W-1:0]       want_row;
    logic                   shift_en;

    // clamp out-of-range settings
    always_comb
    begin
        r_eff = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0)
            w_eff = IMGW_W'(1);
        else if (width_reg > IMGW_W'(MAX_WIDTH))
            w_eff = IMGW_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = IMGH_W'(1);
        else if (height_reg > IMGH_W'(MAX_HEIGHT))
            h_eff = IMGH_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
        r_ext = D_W'(r_eff);
        w_ext = D_W'(w_eff);
        // output trails input by radius rows plus radius columns
        d_eff = (r_ext * w_ext) + r_ext;
    end

    assign pix.ready = (state_reg == ST_IDLE);
    assign take      = pix.valid && pix.ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign row_act  = (in_row_reg < ROW_W'(h_eff));
    // a flush while pixels are still expected is dropped without effect
    assign ignore   = pix.cmd && row_act;
    assign col_wrap = ((IMGW_W'(in_col_reg) + IMGW_W'(1)) == w_eff);
    assign out_wrap = ((IMGW_W'(out_c_reg) + IMGW_W'(1)) == w_eff);
    assign emit_now = (p_reg >= P_W'(d_eff));
    assign k_over   = (out_r_reg >= ROW_W'(h_eff));
    assign k_last   = (out_r_reg == (ROW_W'(h_eff) - ROW_W'(1)))
                   && (IMGW_W'(out_c_reg) == (w_eff - IMGW_W'(1)));
    assign val_raddr = p_reg[VAL_AW-1:0] - d_eff[VAL_AW-1:0];

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        radius_next    = radius_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        p_next         = p_reg;
        out_c_next     = out_c_reg;
        out_r_next     = out_r_reg;
        res_valid_next = res_valid_reg;
        res_val_next   = res_val_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_last_next  = res_last_reg;

        // drop the result once taken
        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && !ignore)
                begin
                    state_next = ST_SHIFT;
                    p_next     = p_reg + P_W'(1);
                    if (col_wrap)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        in_col_next = in_col_reg + COL_W'(1);
                    end
                    if (emit_now)
                    begin
                        if (out_wrap)
                        begin
                            out_c_next = '0;
                            out_r_next = out_r_reg + ROW_W'(1);
                        end
                        else
                        begin
                            out_c_next = out_c_reg + COL_W'(1);
                        end
                        // frame done: restart at row 0, column 0
                        if (k_over || k_last)
                        begin
                            in_col_next = '0;
                            in_row_next = '0;
                            p_next      = '0;
                            out_c_next  = '0;
                            out_r_next  = '0;
                        end
                    end
                end
            end
            ST_SHIFT:
            begin
                state_next = emit_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_val_next   = near ? '0 : keep_val;
                    res_col_next   = OCOL_W'(kcol_reg);
                    res_row_next   = OROW_W'(krow_reg);
                    res_last_next  = klast_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a write to the radius, width or height register restarts the frame
        if (cfg_wr)
        begin
            in_col_next = '0;
            in_row_next = '0;
            p_next      = '0;
            out_c_next  = '0;
            out_r_next  = '0;
            unique case (paddr[PADDR_W-1:2])
                REG_RADIUS: radius_next = pwdata[RAD_W-1:0];
                REG_WIDTH:  width_next  = pwdata[IMGW_W-1:0];
                REG_HEIGHT: height_next = pwdata[IMGH_W-1:0];
                default:
                begin
                    in_col_next = in_col_reg;
                    in_row_next = in_row_reg;
                    p_next      = p_reg;
                    out_c_next  = out_c_reg;
                    out_r_next  = out_r_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= RAD_W'(MAX_RADIUS);
            width_reg     <= IMGW_W'(MAX_WIDTH);
            height_reg    <= IMGH_W'(MAX_HEIGHT);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            p_reg         <= '0;
            out_c_reg     <= '0;
            out_r_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_val_reg   <= '0;
            res_col_reg   <= '0;
            res_row_reg   <= '0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            p_reg         <= p_next;
            out_c_reg     <= out_c_next;
            out_r_reg     <= out_r_next;
            res_valid_reg <= res_valid_next;
            res_val_reg   <= res_val_next;
            res_col_reg   <= res_col_next;
            res_row_reg   <= res_row_next;
            res_last_reg  <= res_last_next;
        end
    end

    // hold the accepted item for the update cycle
    always_ff @(posedge clk)
    begin
        if (take && !ignore)
        begin
            it_col_reg   <= in_col_reg;
            it_row_reg   <= in_row_reg;
            it_blank_reg <= row_act && (pix.pixel_value <= 0);
            it_val_reg   <= pix.pixel_value;
            it_wr_reg    <= row_act;
            it_waddr_reg <= p_reg[VAL_AW-1:0];
            emit_reg     <= emit_now && !k_over;
            kcol_reg     <= out_c_reg;
            krow_reg     <= out_r_reg;
            klast_reg    <= k_last;
        end
    end

    // value ring: read the delayed value on accept, write the new one after
    always_ff @(posedge clk)
    begin
        if (take && !ignore)
        begin
            val_rdata_reg <= value_mem[val_raddr];
        end
        if ((state_reg == ST_SHIFT) && it_wr_reg)
        begin
            value_mem[it_waddr_reg] <= it_val_reg;
        end
    end

    // zero delay means the output pixel is the one just taken
    assign keep_val = (d_eff == '0) ? it_val_reg : val_rdata_reg;

    assign shift_en = (state_reg == ST_SHIFT);

    dd_colstage u_colstage (
        .clk       (clk),
        .rd_en     (take && !ignore),
        .rd_col    (in_col_reg),
        .upd_en    (shift_en),
        .upd_col   (it_col_reg),
        .upd_row   (it_row_reg),
        .upd_blank (it_blank_reg),
        .radius    (r_eff),
        .col_out   (col_entry)
    );

    // cell j holds the column j positions behind the newest one
    assign link[0]  = col_entry;
    assign want_row = krow_reg + ROW_W'(r_eff);

    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        assign cell_mask[j] = disk_mask(r_eff, CELL_IW'(j));
        if (j < NCELL - 1)
        begin : g_mid
            dd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     (link[j]),
                .d_out    (link[j+1]),
                .mask     (cell_mask[j]),
                .want_row (want_row),
                .hit      (hits[j])
            );
        end
        else
        begin : g_end
            dd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d_in     (link[j]),
                .d_out    (),
                .mask     (cell_mask[j]),
                .want_row (want_row),
                .hit      (hits[j])
            );
        end
    end

    assign near = |hits;

    assign res.valid         = res_valid_reg;
    assign res.mask_value    = res_val_reg;
    assign res.out_col       = res_col_reg;
    assign res.out_row       = res_row_reg;
    assign res.last_of_frame = res_last_reg;

    // register readback
    always_comb
    begin
        unique case (paddr[PADDR_W-1:2])
            REG_RADIUS: prdata = PDATA_W'(radius_reg);
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: hdl/dd_chk.sv
// Port-level checks for the disk dilation block, bound to the top level.
module dd_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic                          pix_cmd,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic signed [dd_pkg::PIX_W-1:0] res_mask_value,
    input logic [dd_pkg::OCOL_W-1:0]     res_out_col,
    input logic [dd_pkg::OROW_W-1:0]     res_out_row,
    input logic                          res_last
);
    import dd_pkg::*;

    // a stalled result beat stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat withdrawn while stalled");

    // and keeps its payload
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_mask_value) && $stable(res_out_col)
            && $stable(res_out_row) && $stable(res_last))
        else $error("result payload changed while stalled");

    // a pixel beat always occupies the block for the following cycle
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_ready && !pix_cmd |=> !pix_ready)
        else $error("pixel beat taken back to back");

    // no result is offered while reset is applied
    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result offered during reset");

endmodule

bind disk_dilation_of_blank_pixels dd_chk u_dd_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pix_cmd        (pix.cmd),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_mask_value (res.mask_value),
    .res_out_col    (res.out_col),
    .res_out_row    (res.out_row),
    .res_last       (res.last_of_frame)
);

FILE: sim/dd_checker.sv
// Checker for the disk dilation block: predicts each result beat and compares it.
module dd_checker
    import dd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dd_pix_if                    pix,
    dd_res_if                    res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [PIX_W-1:0] mask_value;
        logic [OCOL_W-1:0]       out_col;
        logic [OROW_W-1:0]       out_row;
        logic                    last_of_frame;
    } dilated_pix_t;

    dilated_pix_t             dilated_q[$];
    logic [RAD_W-1:0]         radius_cfg;
    logic [IMGW_W-1:0]        width_cfg;
    logic [IMGH_W-1:0]        height_cfg;
    int unsigned              cur_col;
    int unsigned              cur_row;
    bit                       blank_at[int unsigned];
    logic signed [PIX_W-1:0]  sample_at[int unsigned];

    assign pending = dilated_q.size();

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit any_blank_in_disk(int r, int c, int rad, int w, int h);
        int q;
        for (int dy = -rad; dy <= rad; dy++) begin
            if (r + dy < 0 || r + dy >= h) continue;
            for (int dx = -rad; dx <= rad; dx++) begin
                if (dx * dx + dy * dy > rad * rad) continue;
                if (c + dx < 0 || c + dx >= w) continue;
                q = (r + dy) * w + c + dx;
                if (blank_at.exists(q) && blank_at[q]) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void restart_frame();
        cur_col = 0;
        cur_row = 0;
        blank_at.delete();
        sample_at.delete();
    endfunction

    task automatic predict_beat(logic cmd, logic signed [PIX_W-1:0] value);
        int unsigned rad, w, h, n, d, p, k;
        dilated_pix_t e;
        rad = (radius_cfg > MAX_RADIUS) ? MAX_RADIUS : radius_cfg;
        w = clamp_dim(width_cfg, MAX_WIDTH);
        h = clamp_dim(height_cfg, MAX_HEIGHT);
        n = w * h;
        d = rad * w + rad;
        p = cur_row * w + cur_col;
        if (p < n) begin
            if (cmd) return;
            blank_at[p]  = (value <= 0);
            sample_at[p] = value;
        end
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (p < d) return;
        k = p - d;
        if (k >= n) begin
            restart_frame();
            return;
        end
        e.mask_value    = any_blank_in_disk(k / w, k % w, rad, w, h) ? '0 : sample_at[k];
        e.out_col       = OCOL_W'(k % w);
        e.out_row       = OROW_W'(k / w);
        e.last_of_frame = (k == n - 1);
        dilated_q.push_back(e);
        if (e.last_of_frame) restart_frame();
    endtask

    always @(posedge clk or negedge rst_n) begin
        dilated_pix_t e;
        if (!rst_n) begin
            radius_cfg = RAD_W'(20);
            width_cfg  = IMGW_W'(2048);
            height_cfg = IMGH_W'(4096);
            dilated_q.delete();
            restart_frame();
            fail_count = 0;
        end else begin
            // a write to the radius, width or height register restarts the frame and drops what is in flight
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_RADIUS: radius_cfg = pwdata[RAD_W-1:0];
                    REG_WIDTH:  width_cfg  = pwdata[IMGW_W-1:0];
                    REG_HEIGHT: height_cfg = pwdata[IMGH_W-1:0];
                    default: ;
                endcase
                if (paddr[PADDR_W-1:2] <= REG_HEIGHT) begin
                    restart_frame();
                    dilated_q.delete();
                end
            end
            if (pix.valid && pix.ready) predict_beat(pix.cmd, pix.pixel_value);
            if (res.valid && res.ready) begin
                if (dilated_q.size() == 0) begin
                    $error("result beat at row %0d col %0d with nothing expected",
                           res.out_row, res.out_col);
                    fail_count++;
                end else begin
                    e = dilated_q.pop_front();
                    if (res.mask_value !== e.mask_value) begin
                        $error("mask_value expected %0d got %0d", e.mask_value, res.mask_value);
                        fail_count++;
                    end
                    if (res.out_col !== e.out_col) begin
                        $error("out_col expected %0d got %0d", e.out_col, res.out_col);
                        fail_count++;
                    end
                    if (res.out_row !== e.out_row) begin
                        $error("out_row expected %0d got %0d", e.out_row, res.out_row);
                        fail_count++;
                    end
                    if (res.last_of_frame !== e.last_of_frame) begin
                        $error("last_of_frame expected %0d got %0d",
                               e.last_of_frame, res.last_of_frame);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

FILE: sim/tb_disk_dilation_of_blank_pixels.sv
// Testbench top: drives frames and register writes into the disk dilation block.
module tb_disk_dilation_of_blank_pixels;
    import dd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;  // cycles with no beat before giving up
    localparam int SETTLE_WAIT = 12;    // covers an item's pass through the accept, shift and emit states

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles;
    int                   res_stall_left;
    int                   beats_sent;
    int                   frames_done;
    int                   max_radius_seen;
    bit                   no_idle;

    dd_pix_if pix ();
    dd_res_if res ();

    disk_dilation_of_blank_pixels u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dd_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mostly no gap, some short gaps, a few long ones; none in no-idle stretches.
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: hold ready low for random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            res_stall_left = 0;
        end
        else if (res_stall_left > 0)
        begin
            res.ready <= 1'b0;
            res_stall_left--;
        end
        else
        begin
            res.ready <= 1'b1;
            res_stall_left = pick_gap();
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("stalled: %0d cycles with no beat, %0d results outstanding",
                     idle_cycles, pending);
            $display("FAIL");
            $finish;
        end
    end

    // Send one beat; drop valid only when a gap precedes it.
    task automatic send_beat(logic cmd, logic signed [PIX_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.cmd         <= cmd;
        pix.pixel_value <= value;
        do @(posedge clk); while (!pix.ready);
        beats_sent++;
    endtask

    // Wait for every expected result, then let the pipeline settle.
    task automatic drain_to_idle();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [REGIDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [PIX_W-1:0] rand_pixel(int blank_pct);
        if ($urandom_range(0, 99) < blank_pct)
            return ($urandom_range(0, 3) == 0) ? 16'sd0 : -$signed(PIX_W'($urandom_range(1, 32768)));
        return PIX_W'($urandom());
    endfunction

    // Write all three registers (raw values; the block clamps), then run one
    // whole frame: pixels with some early flushes mixed in, then the drain.
    task automatic run_frame(int unsigned rad_raw, int unsigned w_raw, int unsigned h_raw,
                             int blank_pct, int early_pct, int pix_drain_pct);
        int unsigned rad, w, h, n, d;
        write_reg(REG_RADIUS, rad_raw);
        write_reg(REG_WIDTH, w_raw);
        write_reg(REG_HEIGHT, h_raw);
        rad = (rad_raw > MAX_RADIUS) ? MAX_RADIUS : rad_raw;
        w   = (w_raw == 0) ? 1 : (w_raw > MAX_WIDTH) ? MAX_WIDTH : w_raw;
        h   = (h_raw == 0) ? 1 : (h_raw > MAX_HEIGHT) ? MAX_HEIGHT : h_raw;
        n   = w * h;
        d   = rad * w + rad;
        if (rad > max_radius_seen) max_radius_seen = rad;
        for (int unsigned i = 0; i < n; i++)
        begin
            // early flushes are ignored by the block
            if ($urandom_range(0, 99) < early_pct) send_beat(1'b1, PIX_W'($urandom()));
            send_beat(1'b0, rand_pixel(blank_pct));
        end
        // pixels sent while draining act as flush steps
        for (int unsigned i = 0; i < d; i++)
        begin
            if ($urandom_range(0, 99) < pix_drain_pct)
                send_beat(1'b0, PIX_W'($urandom()));
            else
                send_beat(1'b1, PIX_W'($urandom()));
        end
        drain_to_idle();
        frames_done++;
    endtask

    initial
    begin
        int unsigned rad, w, h;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pix.valid       = 1'b0;
        pix.cmd         = 1'b0;
        pix.pixel_value = '0;
        beats_sent      = 0;
        frames_done     = 0;
        max_radius_seen = 0;
        no_idle         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: single pixel at the most negative value, no delay.
        write_reg(REG_RADIUS, 0);
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 1);
        send_beat(1'b0, -16'sd32768);
        drain_to_idle();
        // Directed: value extremes and the blank boundary, early flush between.
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 2);
        send_beat(1'b0, 16'sd32767);
        send_beat(1'b1, 16'sd5);
        send_beat(1'b0, 16'sd0);
        send_beat(1'b0, 16'sd1);
        send_beat(1'b0, -16'sd1);
        send_beat(1'b0, 16'sd2);
        send_beat(1'b0, -16'sd32768);
        send_beat(1'b0, 16'sd32767);
        send_beat(1'b0, 16'sd100);
        drain_to_idle();
        // Directed: one blank in the middle of a radius-1 disk, drained by
        // a mix of flush and pixel beats.
        write_reg(REG_RADIUS, 1);
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        for (int i = 0; i < 9; i++) send_beat(1'b0, (i == 4) ? 16'sd0 : PIX_W'(700 + i));
        send_beat(1'b1, 16'sd0);
        send_beat(1'b1, 16'sd0);
        send_beat(1'b0, 16'sd9);
        send_beat(1'b0, -16'sd9);
        drain_to_idle();
        frames_done += 3;

        // Extremes: out-of-range radius, full radius, zero width and height.
        run_frame(31, 5, 2, 2, 0, 20);
        run_frame(2, 0, 9, 10, 2, 20);
        run_frame(20, 12, 2, 1, 0, 5);
        run_frame(0, 16, 0, 20, 5, 30);

        // Random frames, mostly small, with stretches of no idling.
        while (beats_sent < 1900)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0:       rad = $urandom_range(21, 31);
                1, 2:    rad = $urandom_range(5, 20);
                default: rad = $urandom_range(0, 4);
            endcase
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            run_frame(rad, w, h, $urandom_range(2, 25), $urandom_range(0, 10),
                      $urandom_range(0, 30));
        end
        no_idle = 1'b0;

        drain_to_idle();
        $display("covered %0d frames, %0d input beats, disk radius up to %0d",
                 frames_done, beats_sent, max_radius_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dd_pkg.sv
hdl/dd_if.sv
hdl/dd_colstage.sv
hdl/dd_cell.sv
hdl/disk_dilation_of_blank_pixels.sv
hdl/dd_chk.sv
sim/dd_checker.sv
sim/tb_disk_dilation_of_blank_pixels.sv
